>>> src/tcce_pkg.sv
// Shared constants, types and helpers of the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int NCELLS     = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 2) * COLUMNS;
  localparam int CLEAR_END  = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic CFG_CHAR_ATTR  = 1'b0;
  localparam logic CFG_CLEAR_ATTR = 1'b1;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF
  } op_t;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_position;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] cell_idx(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    cell_idx = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

>>> src/tcce_ram.sv
// Generic single write port, single read port RAM with registered read.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tcce_front.sv
// Front end: classifies incoming words into commands and queues them.
module tcce_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcce_pkg::in_item_t in_word,
  output logic              full,
  output logic              cmd_valid,
  output tcce_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  tcce_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  tcce_pkg::cmd_t cls;

  always_comb begin
    cls.char_code    = in_word.char_code;
    cls.cell_address = in_word.cell_address;
    if (in_word.mode == tcce_pkg::MODE_READ) begin
      cls.op = tcce_pkg::OP_READ;
    end else begin
      case (in_word.char_code)
        tcce_pkg::CH_BS:  cls.op = tcce_pkg::OP_BS;
        tcce_pkg::CH_TAB: cls.op = tcce_pkg::OP_TAB;
        tcce_pkg::CH_CR:  cls.op = tcce_pkg::OP_CR;
        tcce_pkg::CH_LF:  cls.op = tcce_pkg::OP_LF;
        default:          cls.op = tcce_pkg::OP_PRINT;
      endcase
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ cmd_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> src/tcce_back.sv
// Back end: executes commands on the cell store, moves the cursor, queues results.
module tcce_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tcce_pkg::ATTR_W-1:0] char_attr,
  input  logic [tcce_pkg::ATTR_W-1:0] clear_attr,
  input  logic                        cmd_valid,
  input  tcce_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        clearing,
  output logic                        out_empty,
  output tcce_pkg::out_item_t         out_word,
  input  logic                        out_pop
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_BS_WR,
    S_SC_RD,
    S_SC_WR,
    S_SC_CLR,
    S_DONE
  } state_t;

  localparam int ADDR_W = tcce_pkg::ADDR_W;
  localparam int COL_W  = tcce_pkg::COL_W;
  localparam int ROW_W  = tcce_pkg::ROW_W;

  state_t                       state_r, state_nxt;
  logic [COL_W-1:0]             col_r, col_nxt;
  logic [ROW_W-1:0]             row_r, row_nxt;
  logic [ADDR_W-1:0]            cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]            bs_idx_r, bs_idx_nxt;
  logic [tcce_pkg::CHAR_W-1:0]  rc_r, rc_nxt;
  logic [tcce_pkg::ATTR_W-1:0]  ra_r, ra_nxt;

  logic                         we;
  logic [ADDR_W-1:0]            waddr;
  logic [tcce_pkg::CELL_W-1:0]  wdata;
  logic [ADDR_W-1:0]            raddr;
  logic [tcce_pkg::CELL_W-1:0]  rdata;

  logic [COL_W-1:0]             pc;
  logic [ROW_W-1:0]             pr;
  state_t                       put_state;

  tcce_pkg::out_item_t          oq_r [2];
  logic                         oq_wr_r, oq_rd_r;
  logic [1:0]                   oq_cnt_r;
  logic                         oq_full, oq_push;
  tcce_pkg::out_item_t          res;

  tcce_ram #(
    .WIDTH (tcce_pkg::CELL_W),
    .DEPTH (tcce_pkg::NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing = (state_r == S_CLEAR);
  assign oq_full  = (oq_cnt_r == 2'd2);
  assign oq_push  = (state_r == S_DONE) && !oq_full;

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    cnt_nxt    = cnt_r;
    bs_idx_nxt = bs_idx_r;
    rc_nxt     = rc_r;
    ra_nxt     = ra_r;
    we         = 1'b0;
    waddr      = cnt_r;
    wdata      = '0;
    raddr      = cnt_r;
    cmd_pop    = 1'b0;
    pc         = col_r;
    pr         = row_r;
    put_state  = S_DONE;

    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(tcce_pkg::NCELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          rc_nxt  = '0;
          ra_nxt  = '0;
          if (cmd.op == tcce_pkg::OP_READ) begin
            raddr = cmd.cell_address;
            if (cmd.cell_address < ADDR_W'(tcce_pkg::NCELLS)) begin
              state_nxt = S_READ;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            case (cmd.op)
              tcce_pkg::OP_PRINT: begin
                we    = 1'b1;
                waddr = tcce_pkg::cell_idx(row_r, col_r);
                wdata = {char_attr, cmd.char_code};
                pc    = col_r + 1'b1;
              end
              tcce_pkg::OP_BS: begin
                if (col_r != '0) begin
                  pc         = col_r - 1'b1;
                  raddr      = tcce_pkg::cell_idx(row_r, pc);
                  bs_idx_nxt = raddr;
                end
              end
              tcce_pkg::OP_TAB: begin
                pc = col_r - (col_r % COL_W'(tcce_pkg::TAB_WIDTH))
                     + COL_W'(tcce_pkg::TAB_WIDTH);
              end
              tcce_pkg::OP_CR: begin
                pc = '0;
              end
              tcce_pkg::OP_LF: begin
                pc = '0;
                pr = row_r + 1'b1;
              end
              default: begin
                pc = col_r;
              end
            endcase
            if (pc >= COL_W'(tcce_pkg::COLUMNS)) begin
              pc = '0;
              pr = pr + 1'b1;
            end
            if (pr >= ROW_W'(tcce_pkg::ROWS - 1)) begin
              pr      = pr - 1'b1;
              cnt_nxt = (tcce_pkg::COPY_CELLS != 0) ? '0 : ADDR_W'(tcce_pkg::COPY_CELLS);
              put_state = (tcce_pkg::COPY_CELLS != 0) ? S_SC_RD : S_SC_CLR;
            end else if (cmd.op == tcce_pkg::OP_BS && col_r != '0) begin
              put_state = S_BS_WR;
            end
            col_nxt   = pc;
            row_nxt   = pr;
            state_nxt = put_state;
          end
        end
      end

      S_READ: begin
        rc_nxt    = rdata[tcce_pkg::CHAR_W-1:0];
        ra_nxt    = rdata[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];
        state_nxt = S_DONE;
      end

      S_BS_WR: begin
        we        = 1'b1;
        waddr     = bs_idx_r;
        wdata     = {rdata[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W], tcce_pkg::CHAR_W'(0)};
        state_nxt = S_DONE;
      end

      S_SC_RD: begin
        raddr     = cnt_r + ADDR_W'(tcce_pkg::COLUMNS);
        state_nxt = S_SC_WR;
      end

      S_SC_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(tcce_pkg::COPY_CELLS - 1)) begin
          state_nxt = S_SC_CLR;
        end else begin
          state_nxt = S_SC_RD;
        end
      end

      S_SC_CLR: begin
        we      = 1'b1;
        wdata   = {clear_attr, tcce_pkg::CHAR_W'(0)};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(tcce_pkg::CLEAR_END - 1)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!oq_full) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
    end
    bs_idx_r <= bs_idx_nxt;
    rc_r     <= rc_nxt;
    ra_r     <= ra_nxt;
  end

  // result queue
  always_comb begin
    res.cursor_col      = col_r;
    res.cursor_row      = row_r;
    res.cursor_position = tcce_pkg::cell_idx(row_r, col_r);
    res.read_char       = rc_r;
    res.read_attr       = ra_r;
  end

  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_word  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= oq_wr_r ^ oq_push;
      oq_rd_r  <= oq_rd_r ^ (out_pop && !out_empty);
      oq_cnt_r <= oq_cnt_r + {1'b0, oq_push} - {1'b0, out_pop && !out_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

>>> src/text_console_cursor_engine.sv
// Text console cursor engine: top level with configuration registers.
//
// Input words (mode, char_code, cell_address) are pushed with in_push while
// in_full is low. Results (cursor column, row, linear position and, for a
// read, the addressed cell) come out in order: a result is on out_word while
// out_empty is low and is taken with out_pop.
// cfg_we writes char_attribute (index 0) or clear_attribute (index 1).
// Carriage return, line feed, tab, printable bytes, out-of-range reads and
// backspace at column 0 go from the idle state straight to the result
// state; other reads and backspaces first pass through a read or write
// state. A put that reaches the last text row scrolls the cell store
// through its single read and single write port, a read state and a write
// state per copied cell, then clears the freed row. The back end takes one
// command at a time and passes through a result state, which waits while
// the result queue is full. After reset the cell store is swept to zero,
// one cell per cycle, with in_full held high. A stalled receiver fills the
// two-deep result queue, then the two-deep command queue, then in_full rises.
module text_console_cursor_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  tcce_pkg::in_item_t                    in_word,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output tcce_pkg::out_item_t                   out_word,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [tcce_pkg::ATTR_W-1:0]           cfg_data
);

  logic [tcce_pkg::ATTR_W-1:0] char_attr_r;
  logic [tcce_pkg::ATTR_W-1:0] clear_attr_r;
  logic                        front_full;
  logic                        clearing;
  logic                        push_ok;
  logic                        cmd_valid;
  logic                        cmd_pop;
  tcce_pkg::cmd_t              cmd;

  assign in_full = front_full || clearing;
  assign push_ok = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_attr_r  <= tcce_pkg::ATTR_RESET;
      clear_attr_r <= tcce_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcce_pkg::CFG_CHAR_ATTR:  char_attr_r  <= cfg_data;
        tcce_pkg::CFG_CLEAR_ATTR: clear_attr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_ok),
    .in_word   (in_word),
    .full      (front_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_attr  (char_attr_r),
    .clear_attr (clear_attr_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .clearing   (clearing),
    .out_empty  (out_empty),
    .out_word   (out_word),
    .out_pop    (out_pop)
  );

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input open right after reset");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_word.cursor_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1))
    else $error("cursor on bottom row");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_word.cursor_col < tcce_pkg::COL_W'(tcce_pkg::COLUMNS))
    else $error("cursor column out of range");

  a_position: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_word.cursor_position ==
      tcce_pkg::cell_idx(out_word.cursor_row, out_word.cursor_col))
    else $error("cursor position mismatch");

endmodule
